### rtl/fifo_with_priority_extract_macros.svh
// ----------------------------------------------------------------------------
// fifo_with_priority_extract assertion macros
// Shared concurrent assertion forms, clocked on clk and held off during rst.
// ----------------------------------------------------------------------------
`ifndef FIFO_WITH_PRIORITY_EXTRACT_MACROS_SVH
`define FIFO_WITH_PRIORITY_EXTRACT_MACROS_SVH

// Same-cycle implication.
`define FWPE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FWPE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/fwpe_pkg.sv
// ----------------------------------------------------------------------------
// fwpe_pkg
// Request/response payload types and operation codes of the priority queue.
// ----------------------------------------------------------------------------
package fwpe_pkg;

  localparam int unsigned COUNT_W = 5;

  localparam logic [1:0] OP_PUSH    = 2'd0;
  localparam logic [1:0] OP_POP     = 2'd1;
  localparam logic [1:0] OP_EXTRACT = 2'd2;

  typedef struct packed {
    logic [1:0]         operation;
    logic [31:0]        entry_tag;
    logic signed [31:0] entry_priority;
  } fwpe_in_t;

  typedef struct packed {
    logic               found;
    logic [31:0]        out_tag;
    logic signed [31:0] out_priority;
    logic               dropped;
    logic [COUNT_W-1:0] entry_count;
  } fwpe_out_t;

  // One stored queue entry.
  typedef struct packed {
    logic [31:0]        tag;
    logic signed [31:0] prio;
  } fwpe_entry_t;

  localparam int unsigned ENTRY_W = $bits(fwpe_entry_t);

endpackage

### rtl/fwpe_ram.sv
// ----------------------------------------------------------------------------
// fwpe_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module fwpe_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/fifo_with_priority_extract.sv
// ----------------------------------------------------------------------------
// fifo_with_priority_extract
// Bounded ordered queue of (tag, signed priority) entries with pop-oldest and
// extract-highest-priority, held in a circular buffer in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready/in_data carry one request: push, pop or extract.
//   out_valid/out_ready/out_data return exactly one response per request,
//   always with the entry count after the operation (low 5 bits).
//   One request is worked on at a time; in_ready is high only while idle, so
//   the next request waits until the last response has gone to the output.
//   A push, or any request that finds nothing to do, goes straight to the
//   response; a pop first reads the oldest entry.
//   Extract scans every entry through the single RAM read port, one per
//   cycle, then closes the gap by moving each younger entry down one slot
//   (read and write port busy together).
//   The next request is taken as soon as the response is loaded into the
//   output register, even while the receiver still stalls it; a finished
//   response waits in its own state until the output register is free.
//   Reset empties the queue at once (count and head cleared); RAM contents
//   are never read before being written, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module fifo_with_priority_extract #(
  parameter int unsigned QUEUE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fwpe_pkg::fwpe_in_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output fwpe_pkg::fwpe_out_t out_data
);

  import fwpe_pkg::*;

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);      // physical slot index
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);  // count / logical index

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_SCAN,
    S_SHIFT_START,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t      state;
  logic [PW-1:0] head;         // slot of the oldest entry
  logic [CW-1:0] count;
  logic [CW-1:0] rd_idx;       // next logical index to read in the scan
  logic [CW-1:0] cmp_idx;      // logical index of the data now on rd_data
  logic [CW-1:0] best_idx;
  logic [CW-1:0] wr_idx;       // compaction destination
  fwpe_entry_t best;
  fwpe_out_t   res;

  logic              ram_we;
  logic [PW-1:0]     ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic              ram_re;
  logic [PW-1:0]     ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  fwpe_entry_t       rd_entry;

  logic in_fire;
  logic out_free;

  // Logical position k (0 = oldest) to RAM slot, wrapping at QUEUE_DEPTH.
  function automatic logic [PW-1:0] phys(input logic [PW-1:0] hd,
                                          input logic [CW-1:0] k);
    logic [CW:0] sum;
    sum = (CW+1)'(hd) + (CW+1)'(k);
    if (sum >= (CW+1)'(QUEUE_DEPTH)) begin
      sum = sum - (CW+1)'(QUEUE_DEPTH);
    end
    return PW'(sum);
  endfunction

  // Response word; the count is reported in its low bits.
  function automatic fwpe_out_t make_resp(input logic fnd, input fwpe_entry_t ent,
                                          input logic drp, input logic [CW-1:0] cnt);
    fwpe_out_t r;
    r.found        = fnd;
    r.out_tag      = ent.tag;
    r.out_priority = ent.prio;
    r.dropped      = drp;
    r.entry_count  = COUNT_W'(cnt);
    return r;
  endfunction

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign rd_entry = fwpe_entry_t'(ram_rdata);

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          case (in_data.operation)
            OP_PUSH: begin
              if (count < CW'(QUEUE_DEPTH)) begin
                ram_we    = 1'b1;
                ram_waddr = phys(head, count);
                ram_wdata = {in_data.entry_tag, in_data.entry_priority};
              end
            end
            OP_POP, OP_EXTRACT: begin
              if (count != '0) begin
                ram_re    = 1'b1;
                ram_raddr = head;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (rd_idx < count) begin
          ram_re    = 1'b1;
          ram_raddr = phys(head, rd_idx);
        end
      end
      S_SHIFT_START: begin
        if (CW'(best_idx + CW'(1)) < count) begin
          ram_re    = 1'b1;
          ram_raddr = phys(head, CW'(best_idx + CW'(1)));
        end
      end
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head, wr_idx);
        ram_wdata = ram_rdata;
        if (CW'(wr_idx + CW'(2)) < count) begin
          ram_re    = 1'b1;
          ram_raddr = phys(head, CW'(wr_idx + CW'(2)));
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      // output register: loaded from S_RESP, emptied when taken
      if (state == S_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (in_data.operation)
              OP_PUSH: begin
                if (count < CW'(QUEUE_DEPTH)) begin
                  count <= CW'(count + CW'(1));
                  res   <= make_resp(1'b0, '0, 1'b0, CW'(count + CW'(1)));
                end else begin
                  res   <= make_resp(1'b0, '0, 1'b1, count);
                end
                state <= S_RESP;
              end
              OP_POP: begin
                if (count != '0) begin
                  state <= S_POP;
                end else begin
                  res   <= make_resp(1'b0, '0, 1'b0, count);
                  state <= S_RESP;
                end
              end
              OP_EXTRACT: begin
                if (count != '0) begin
                  rd_idx  <= CW'(1);
                  cmp_idx <= '0;
                  state   <= S_SCAN;
                end else begin
                  res   <= make_resp(1'b0, '0, 1'b0, count);
                  state <= S_RESP;
                end
              end
              default: begin
                res   <= make_resp(1'b0, '0, 1'b0, count);
                state <= S_RESP;
              end
            endcase
          end
        end
        S_POP: begin
          res   <= make_resp(1'b1, rd_entry, 1'b0, CW'(count - CW'(1)));
          head  <= phys(head, CW'(1));
          count <= CW'(count - CW'(1));
          state <= S_RESP;
        end
        S_SCAN: begin
          // Strict compare: ties keep the oldest candidate.
          if (cmp_idx == '0 || rd_entry.prio > best.prio) begin
            best     <= rd_entry;
            best_idx <= cmp_idx;
          end
          if (rd_idx < count) begin
            rd_idx <= CW'(rd_idx + CW'(1));
          end
          cmp_idx <= CW'(cmp_idx + CW'(1));
          if (cmp_idx == CW'(count - CW'(1))) begin
            state <= S_SHIFT_START;
          end
        end
        S_SHIFT_START: begin
          res <= make_resp(1'b1, best, 1'b0, CW'(count - CW'(1)));
          if (CW'(best_idx + CW'(1)) < count) begin
            wr_idx <= best_idx;
            state  <= S_SHIFT;
          end else begin
            count <= CW'(count - CW'(1));
            state <= S_RESP;
          end
        end
        S_SHIFT: begin
          wr_idx <= CW'(wr_idx + CW'(1));
          if (!(CW'(wr_idx + CW'(2)) < count)) begin
            count <= CW'(count - CW'(1));
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_data <= res;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  fwpe_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

endmodule

### rtl/fwpe_checker.sv
// ----------------------------------------------------------------------------
// fwpe_checker
// Port-level assertions for fifo_with_priority_extract, bound to the top.
// ----------------------------------------------------------------------------
`include "fifo_with_priority_extract_macros.svh"

module fwpe_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input fwpe_pkg::fwpe_in_t in_data,
  input logic               out_valid,
  input logic               out_ready,
  input fwpe_pkg::fwpe_out_t out_data
);

  // A stalled response stays put.
  `FWPE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                    out_valid && $stable(out_data), "response changed while stalled")

  // One request at a time: taking a request closes the input.
  `FWPE_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready,
                    "request accepted while another in progress")

  // A response never both removes an entry and drops a push.
  `FWPE_ASSERT_NOW(a_found_xor_drop, out_valid, !(out_data.found && out_data.dropped),
                   "found and dropped both set")

  // Nothing removed means zero tag and priority.
  `FWPE_ASSERT_NOW(a_empty_payload, out_valid && !out_data.found,
                   out_data.out_tag == '0 && out_data.out_priority == '0,
                   "nonzero payload without a removed entry")

endmodule

bind fifo_with_priority_extract fwpe_checker u_fwpe_checker (.*);
